[rtl/core/fmdt_pkg.sv]
// fmdt_pkg: request types and constants for the dual timer status block.
// Standalone package; used by fm_chip_dual_timer_status by scoped names.
package fmdt_pkg;

    // Request kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register map
    localparam logic [7:0] ADDR_A_HIGH  = 8'h10;
    localparam logic [7:0] ADDR_A_LOW   = 8'h11;
    localparam logic [7:0] ADDR_B_LOAD  = 8'h12;
    localparam logic [7:0] ADDR_CONTROL = 8'h14;

    // Counter tops
    localparam logic [9:0] A_TOP = 10'd1023;
    localparam logic [7:0] B_TOP = 8'd255;

    // Timer bit positions within the two-bit groups
    localparam int unsigned TMR_A = 0;
    localparam int unsigned TMR_B = 1;

    // Control register bit positions
    localparam int unsigned CTL_RUN_A = 0;
    localparam int unsigned CTL_RUN_B = 1;
    localparam int unsigned CTL_EN_A  = 2;
    localparam int unsigned CTL_EN_B  = 3;
    localparam int unsigned CTL_CLR_A = 4;
    localparam int unsigned CTL_CLR_B = 5;

    typedef struct packed {
        logic       kind;
        logic [7:0] reg_address;
        logic [7:0] reg_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status_flags;
        logic [9:0] timer_a_value;
        logic [7:0] timer_b_value;
    } out_item_t;

endpackage

[rtl/core/fm_chip_dual_timer_status.sv]
// fm_chip_dual_timer_status: two up-counting timers with overflow status flags.
// Registered path: an accepted request passes the input register, then the result register.
// Throughput: one request per cycle while results drain; the timer update is one pass between the two.
// The input register lets a request be taken while a finished result waits downstream.
// Reset (rst_n, asynchronous, active low): both timers stopped, counters at top, flags clear.
// Depends on fmdt_pkg for the request/result types and register map.
module fm_chip_dual_timer_status #(
    parameter int B_PRESCALE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fmdt_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fmdt_pkg::out_item_t out_data
);

    // Prescaler width; at least one bit so a divide-by-one still elaborates
    localparam int PS_W = (B_PRESCALE > 1) ? $clog2(B_PRESCALE) : 1;
    localparam logic [PS_W-1:0] PS_LAST = PS_W'(B_PRESCALE - 1);

    // ---------------------------------------------------------------
    // Handshake: input register feeds the result register
    // ---------------------------------------------------------------
    logic               in_valid_reg;
    fmdt_pkg::in_item_t in_item_reg;
    logic               out_valid_reg;
    fmdt_pkg::out_item_t out_item_reg;
    logic               advance;

    // A held request moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // ---------------------------------------------------------------
    // Timer state
    // ---------------------------------------------------------------
    logic [9:0]      a_count_reg, a_count_next;
    logic [9:0]      a_reload_reg, a_reload_next;
    logic [7:0]      b_count_reg, b_count_next;
    logic [7:0]      b_reload_reg, b_reload_next;
    logic [PS_W-1:0] prescale_reg, prescale_next;
    logic [1:0]      run_reg, run_next;
    logic [1:0]      enable_reg, enable_next;
    logic [1:0]      loaded_reg, loaded_next;
    logic [1:0]      flag_reg, flag_next;
    logic            ps_terminal;

    assign ps_terminal = (prescale_reg == PS_LAST);

    always_comb
    begin
        a_count_next  = a_count_reg;
        a_reload_next = a_reload_reg;
        b_count_next  = b_count_reg;
        b_reload_next = b_reload_reg;
        prescale_next = prescale_reg;
        run_next      = run_reg;
        enable_next   = enable_reg;
        loaded_next   = loaded_reg;
        flag_next     = flag_reg;

        if (in_item_reg.kind == fmdt_pkg::KIND_TICK)
        begin
            // Timer A: counts every tick while running
            if (run_reg[fmdt_pkg::TMR_A])
            begin
                if (a_count_reg != fmdt_pkg::A_TOP)
                begin
                    a_count_next = a_count_reg + 10'd1;
                end
                else
                begin
                    // first overflow after a start load is silent
                    if (loaded_reg[fmdt_pkg::TMR_A])
                        loaded_next[fmdt_pkg::TMR_A] = 1'b0;
                    else if (enable_reg[fmdt_pkg::TMR_A])
                        flag_next[fmdt_pkg::TMR_A] = 1'b1;
                    a_count_next = a_reload_reg;
                end
            end

            // Prescaler free-runs; timer B steps on its terminal count
            if (ps_terminal)
            begin
                prescale_next = '0;
                if (run_reg[fmdt_pkg::TMR_B])
                begin
                    if (b_count_reg != fmdt_pkg::B_TOP)
                    begin
                        b_count_next = b_count_reg + 8'd1;
                    end
                    else
                    begin
                        if (loaded_reg[fmdt_pkg::TMR_B])
                            loaded_next[fmdt_pkg::TMR_B] = 1'b0;
                        else if (enable_reg[fmdt_pkg::TMR_B])
                            flag_next[fmdt_pkg::TMR_B] = 1'b1;
                        b_count_next = b_reload_reg;
                    end
                end
            end
            else
            begin
                prescale_next = prescale_reg + PS_W'(1);
                // quirk: a pending B load lands on any non-terminal tick, run or not
                if (loaded_reg[fmdt_pkg::TMR_B])
                begin
                    loaded_next[fmdt_pkg::TMR_B] = 1'b0;
                    b_count_next = b_reload_reg;
                end
            end
        end
        else
        begin
            case (in_item_reg.reg_address)
                fmdt_pkg::ADDR_A_HIGH:
                begin
                    a_reload_next[9:2] = in_item_reg.reg_data;
                end
                fmdt_pkg::ADDR_A_LOW:
                begin
                    a_reload_next[1:0] = in_item_reg.reg_data[1:0];
                end
                fmdt_pkg::ADDR_B_LOAD:
                begin
                    b_reload_next = in_item_reg.reg_data;
                end
                fmdt_pkg::ADDR_CONTROL:
                begin
                    // start from stopped: preset to top, mark pending load
                    if (in_item_reg.reg_data[fmdt_pkg::CTL_RUN_A] && !run_reg[fmdt_pkg::TMR_A])
                    begin
                        a_count_next = fmdt_pkg::A_TOP;
                        loaded_next[fmdt_pkg::TMR_A] = 1'b1;
                    end
                    if (in_item_reg.reg_data[fmdt_pkg::CTL_RUN_B] && !run_reg[fmdt_pkg::TMR_B])
                    begin
                        b_count_next = fmdt_pkg::B_TOP;
                        loaded_next[fmdt_pkg::TMR_B] = 1'b1;
                    end
                    run_next    = in_item_reg.reg_data[fmdt_pkg::CTL_RUN_B:fmdt_pkg::CTL_RUN_A];
                    enable_next = in_item_reg.reg_data[fmdt_pkg::CTL_EN_B:fmdt_pkg::CTL_EN_A];
                    if (in_item_reg.reg_data[fmdt_pkg::CTL_CLR_A])
                        flag_next[fmdt_pkg::TMR_A] = 1'b0;
                    if (in_item_reg.reg_data[fmdt_pkg::CTL_CLR_B])
                        flag_next[fmdt_pkg::TMR_B] = 1'b0;
                end
                default:
                begin
                    // unmapped address: write ignored
                end
            endcase
        end
    end

    // Control and timer state; commits only when a request passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            a_count_reg   <= fmdt_pkg::A_TOP;
            a_reload_reg  <= '0;
            b_count_reg   <= fmdt_pkg::B_TOP;
            b_reload_reg  <= '0;
            prescale_reg  <= '0;
            run_reg       <= '0;
            enable_reg    <= '0;
            loaded_reg    <= '0;
            flag_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                a_count_reg  <= a_count_next;
                a_reload_reg <= a_reload_next;
                b_count_reg  <= b_count_next;
                b_reload_reg <= b_reload_next;
                prescale_reg <= prescale_next;
                run_reg      <= run_next;
                enable_reg   <= enable_next;
                loaded_reg   <= loaded_next;
                flag_reg     <= flag_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (advance)
        begin
            out_item_reg.status_flags  <= flag_next;
            out_item_reg.timer_a_value <= a_count_next;
            out_item_reg.timer_b_value <= b_count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

`ifndef ASSERT_OFF
    // a flag only ever sets while its enable is on
    a_flag_a_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(flag_reg[fmdt_pkg::TMR_A]) && flag_reg[fmdt_pkg::TMR_A])
            |-> enable_reg[fmdt_pkg::TMR_A])
        else $error("timer A flag set while disabled");
    a_flag_b_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(flag_reg[fmdt_pkg::TMR_B]) && flag_reg[fmdt_pkg::TMR_B])
            |-> enable_reg[fmdt_pkg::TMR_B])
        else $error("timer B flag set while disabled");
    // back-pressure only when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");
    // a passed request always yields a result
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("request passed without a result");
    // prescaler never beyond its terminal count
    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(prescale_reg) < B_PRESCALE))
        else $error("prescaler out of range");
`endif

endmodule

[test/testbench.sv]
// testbench: self-checking bench for fm_chip_dual_timer_status (two timers, status flags).
// Depends on fmdt_pkg for the request/result types, register map and counter tops.
// Holds its own timer predictor; random content comes from the simulator's seed.
`timescale 1ns / 100ps

module testbench;

    localparam int B_PRESCALE  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    fmdt_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    fmdt_pkg::out_item_t out_data;

    fm_chip_dual_timer_status #(
        .B_PRESCALE (B_PRESCALE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer predictor state, a private copy of what the block should hold
    // ------------------------------------------------------------------
    logic [9:0] a_count;
    logic [9:0] a_reload;
    logic [7:0] b_count;
    logic [7:0] b_reload;
    int         prescale_count;
    logic [1:0] run_bits;
    logic [1:0] flag_enable;
    logic [1:0] load_pending;
    logic [1:0] flags;

    fmdt_pkg::in_item_t  request_queue[$];   // requests waiting for the driver
    fmdt_pkg::out_item_t status_due[$];      // predicted results, oldest first

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;         // bumped by the sequencer to ask for a long stall
    int holds_started = 0;
    int hold_left     = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;
    bit req_taken     = 1'b0;

    // One tick or one register write, exactly as the block should see it.
    function automatic fmdt_pkg::out_item_t predict_timer_status(fmdt_pkg::in_item_t req);
        fmdt_pkg::out_item_t res;
        if (req.kind == fmdt_pkg::KIND_TICK)
        begin
            if (run_bits[fmdt_pkg::TMR_A])
            begin
                if (a_count != fmdt_pkg::A_TOP)
                    a_count = a_count + 10'd1;
                else
                begin
                    // first overflow after a start load is silent
                    if (load_pending[fmdt_pkg::TMR_A])
                        load_pending[fmdt_pkg::TMR_A] = 1'b0;
                    else if (flag_enable[fmdt_pkg::TMR_A])
                        flags[fmdt_pkg::TMR_A] = 1'b1;
                    a_count = a_reload;
                end
            end
            // prescaler always runs, whether B runs or not
            prescale_count = prescale_count + 1;
            if (prescale_count >= B_PRESCALE)
            begin
                prescale_count = 0;
                if (run_bits[fmdt_pkg::TMR_B])
                begin
                    if (b_count != fmdt_pkg::B_TOP)
                        b_count = b_count + 8'd1;
                    else
                    begin
                        if (load_pending[fmdt_pkg::TMR_B])
                            load_pending[fmdt_pkg::TMR_B] = 1'b0;
                        else if (flag_enable[fmdt_pkg::TMR_B])
                            flags[fmdt_pkg::TMR_B] = 1'b1;
                        b_count = b_reload;
                    end
                end
            end
            else if (load_pending[fmdt_pkg::TMR_B])
            begin
                // B quirk: pending load lands on a non-terminal tick
                load_pending[fmdt_pkg::TMR_B] = 1'b0;
                b_count = b_reload;
            end
        end
        else
        begin
            case (req.reg_address)
                fmdt_pkg::ADDR_A_HIGH:  a_reload[9:2] = req.reg_data;
                fmdt_pkg::ADDR_A_LOW:   a_reload[1:0] = req.reg_data[1:0];
                fmdt_pkg::ADDR_B_LOAD:  b_reload = req.reg_data;
                fmdt_pkg::ADDR_CONTROL:
                begin
                    if (req.reg_data[fmdt_pkg::CTL_RUN_A] && !run_bits[fmdt_pkg::TMR_A])
                    begin
                        a_count = fmdt_pkg::A_TOP;
                        load_pending[fmdt_pkg::TMR_A] = 1'b1;
                    end
                    if (req.reg_data[fmdt_pkg::CTL_RUN_B] && !run_bits[fmdt_pkg::TMR_B])
                    begin
                        b_count = fmdt_pkg::B_TOP;
                        load_pending[fmdt_pkg::TMR_B] = 1'b1;
                    end
                    run_bits    = req.reg_data[fmdt_pkg::CTL_RUN_B:fmdt_pkg::CTL_RUN_A];
                    flag_enable = req.reg_data[fmdt_pkg::CTL_EN_B:fmdt_pkg::CTL_EN_A];
                    if (req.reg_data[fmdt_pkg::CTL_CLR_A])
                        flags[fmdt_pkg::TMR_A] = 1'b0;
                    if (req.reg_data[fmdt_pkg::CTL_CLR_B])
                        flags[fmdt_pkg::TMR_B] = 1'b0;
                end
                default: ;
            endcase
        end
        res.status_flags  = flags;
        res.timer_a_value = a_count;
        res.timer_b_value = b_count;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected result flags=%0h a=%0d b=%0d", $time,
                         out_data.status_flags, out_data.timer_a_value,
                         out_data.timer_b_value);
                mismatch_count++;
            end
            else
            begin
                fmdt_pkg::out_item_t due;
                due = status_due.pop_front();
                if (out_data.status_flags !== due.status_flags)
                begin
                    $display("%0t: status_flags expected %0h actual %0h", $time,
                             due.status_flags, out_data.status_flags);
                    mismatch_count++;
                end
                if (out_data.timer_a_value !== due.timer_a_value)
                begin
                    $display("%0t: timer_a_value expected %0d actual %0d", $time,
                             due.timer_a_value, out_data.timer_a_value);
                    mismatch_count++;
                end
                if (out_data.timer_b_value !== due.timer_b_value)
                begin
                    $display("%0t: timer_b_value expected %0d actual %0d", $time,
                             due.timer_b_value, out_data.timer_b_value);
                    mismatch_count++;
                end
            end
        end
        // a request accepted here gets its prediction straight away
        req_taken = in_valid && in_ready;
        if (req_taken)
            status_due.insert(status_due.size(), predict_timer_status(in_data));
    end

    // ------------------------------------------------------------------
    // Driver: offers the next request at the falling edge, holds it until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                in_data  <= request_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holds_started != hold_requests)
            begin
                holds_started = hold_requests;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_write(input logic [7:0] addr, input logic [7:0] data);
        fmdt_pkg::in_item_t req;
        req.kind        = fmdt_pkg::KIND_WRITE;
        req.reg_address = addr;
        req.reg_data    = data;
        request_queue.insert(request_queue.size(), req);
    endtask

    // Ticks carry random address/data; the block must ignore them.
    task automatic queue_ticks(input int n);
        fmdt_pkg::in_item_t req;
        for (int i = 0; i < n; i++)
        begin
            req.kind        = fmdt_pkg::KIND_TICK;
            req.reg_address = 8'($urandom_range(255));
            req.reg_data    = 8'($urandom_range(255));
            request_queue.insert(request_queue.size(), req);
        end
    endtask

    // Mostly well-formed runs: set reloads near the top so overflows come
    // often, start the timers, then tick. The rest is noise and lone
    // control writes that stop, restart or clear mid-run.
    task automatic queue_random_batch(input int target);
        int         queued;
        int         roll;
        int         n;
        logic [7:0] ctl;
        queued = 0;
        while (queued < target)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                queue_write(8'($urandom_range(255)), 8'($urandom_range(255)));
                queued++;
            end
            else if (roll < 18)
            begin
                queue_write(fmdt_pkg::ADDR_CONTROL, 8'($urandom_range(255)));
                queued++;
            end
            else
            begin
                // stop first at times so the start below loads the tops
                if ($urandom_range(1) == 0)
                begin
                    ctl = 8'($urandom_range(255));
                    ctl[fmdt_pkg::CTL_RUN_B:fmdt_pkg::CTL_RUN_A] = 2'b00;
                    queue_write(fmdt_pkg::ADDR_CONTROL, ctl);
                    queued++;
                end
                queue_write(fmdt_pkg::ADDR_A_HIGH, ($urandom_range(3) == 0) ?
                            8'($urandom_range(255)) : 8'($urandom_range(8'hF0, 8'hFF)));
                queue_write(fmdt_pkg::ADDR_A_LOW, 8'($urandom_range(255)));
                queue_write(fmdt_pkg::ADDR_B_LOAD, ($urandom_range(3) == 0) ?
                            8'($urandom_range(255)) : 8'($urandom_range(8'hF8, 8'hFF)));
                ctl = 8'($urandom_range(255));
                if ($urandom_range(3) != 0)
                    ctl[fmdt_pkg::CTL_RUN_B:fmdt_pkg::CTL_RUN_A] = 2'b11;
                if ($urandom_range(2) != 0)
                    ctl[fmdt_pkg::CTL_EN_B:fmdt_pkg::CTL_EN_A] = 2'b11;
                queue_write(fmdt_pkg::ADDR_CONTROL, ctl);
                n = $urandom_range(4, 48);
                queue_ticks(n);
                queued += 4 + n;
            end
        end
    endtask

    // Sender pauses here until every predicted result is back.
    task automatic wait_drained();
        while (request_queue.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed requests, then three idling phases
    // ------------------------------------------------------------------
    initial
    begin
        a_count        = fmdt_pkg::A_TOP;
        a_reload       = '0;
        b_count        = fmdt_pkg::B_TOP;
        b_reload       = '0;
        prescale_count = 0;
        run_bits       = '0;
        flag_enable    = '0;
        load_pending   = '0;
        flags          = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase 1: sender idles often, receiver idles a lot
        tx_idle_pct = 37;
        rx_idle_pct = 79;

        // Directed: tick while stopped (prescaler only), reloads at their
        // extremes with unused data bits set, start both timers so A
        // overflows at once with its silent start load, then sits at top
        // and overflows every tick; B takes its pending load on the next
        // non-terminal tick and overflows at the prescaler wrap.
        queue_ticks(1);
        queue_write(fmdt_pkg::ADDR_A_HIGH, 8'hFF);
        queue_write(fmdt_pkg::ADDR_A_LOW, 8'hFF);
        queue_write(fmdt_pkg::ADDR_B_LOAD, 8'hFF);
        queue_write(fmdt_pkg::ADDR_CONTROL, 8'h0F);
        queue_ticks(2);
        queue_write(fmdt_pkg::ADDR_CONTROL, 8'h1F);      // clear A flag while running
        queue_ticks(14);
        queue_write(8'hFF, 8'hAA);                        // unmapped register
        queue_write(fmdt_pkg::ADDR_CONTROL, 8'h30);      // stop both and clear both flags
        queue_write(fmdt_pkg::ADDR_A_HIGH, 8'h00);
        queue_write(fmdt_pkg::ADDR_A_LOW, 8'h00);
        queue_write(fmdt_pkg::ADDR_B_LOAD, 8'h00);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 79;
                end
                1:
                begin
                    tx_idle_pct = 79;
                    rx_idle_pct = 37;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // long receiver stall while the sender keeps offering
            if (phase != 1)
                hold_requests++;
            queue_random_batch(190);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
